/* rtl/vat_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vat_pkg
// shared types and constants of the vertex affine transform unit
// ----------------------------------------------------------------------------
package vat_pkg;

    localparam int COEF_FRAC_BITS = 16;
    localparam int POS_FRAC_BITS  = 16;
    localparam int NCOEF          = 12;
    localparam int CIDX_W         = 4;
    localparam int WORD_W         = 32;
    localparam int NRM_W          = 16;
    localparam int S_TDATA_W      = 232;
    localparam int M_TDATA_W      = 144;
    localparam int M_TUSER_W      = 2;

    localparam int PROD_W  = 2 * WORD_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MAG_W   = 64;
    localparam int NMAG_W  = 31;
    localparam int ROOT_W  = 32;
    localparam int QUO_W   = 17;
    localparam int NUM_W   = 47;
    localparam int REM_W   = 49;
    localparam int NORM_STEPS = 6;
    localparam int PIPE_STAGES = 64;

    localparam logic [WORD_W-1:0] COEF_ONE = WORD_W'(1) << COEF_FRAC_BITS;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } op_t;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [NRM_W-1:0]  nrm16_t;

    typedef struct packed {
        word_t [2:0]       pos;
        word_t [2:0]       nrm;
        word_t [NCOEF-1:0] coef;
    } vat_job_t;

    typedef struct packed {
        word_t  [2:0] pos;
        nrm16_t [2:0] nrm;
        logic         zero_normal;
        logic         pos_saturated;
    } vat_result_t;

endpackage
`default_nettype wire

/* rtl/vat_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vat_front
// accepts items, applies coefficient loads, issues transform jobs
// ----------------------------------------------------------------------------
module vat_front
    import vat_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 q_full,
    output logic                      q_push,
    output vat_job_t                  q_job
);

    word_t             coef_reg [NCOEF];
    logic              accept;
    logic [CIDX_W-1:0] cidx;
    word_t             cval;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign cidx     = s_tdata[CIDX_W-1:0];
    assign cval     = s_tdata[CIDX_W +: WORD_W];
    assign q_push   = accept && (op_t'(s_tuser) == OP_XFORM);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_job.pos[i] = s_tdata[CIDX_W + WORD_W * (i + 1) +: WORD_W];
            q_job.nrm[i] = s_tdata[CIDX_W + WORD_W * (i + 4) +: WORD_W];
        end
        for (int i = 0; i < NCOEF; i++)
        begin
            q_job.coef[i] = coef_reg[i];
        end
    end

    // matrix resets to identity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_reg[i] <= (i % 5 == 0) ? COEF_ONE : '0;
            end
        end
        else if (accept && (op_t'(s_tuser) == OP_LOAD) && (cidx < CIDX_W'(NCOEF)))
        begin
            coef_reg[cidx] <= cval;
        end
    end

endmodule
`default_nettype wire

/* rtl/vat_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vat_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module vat_queue
    import vat_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire vat_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          job_valid,
    output vat_job_t      job
);

    vat_job_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign job_valid = (count_reg != 2'd0);
    assign job       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && job_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop && job_valid);
        end
    end

endmodule
`default_nettype wire

/* rtl/vat_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vat_back
// transform pipeline: matrix products, saturation, normal normalize,
// pipelined square root and division
// ----------------------------------------------------------------------------
module vat_back
    import vat_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_valid,
    input  wire vat_job_t job,
    output logic          job_pop,
    output logic          res_valid,
    output vat_result_t   res,
    input  wire logic     res_ready
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam int SIDE_LEN = PIPE_STAGES - 4;

    typedef struct packed {
        word_t [2:0] pos;
        logic        sat;
        logic  [2:0] neg;
    } side_t;

    logic                   en;
    logic [PIPE_STAGES-1:0] vld_reg;

    assign en        = !vld_reg[PIPE_STAGES-1] || res_ready;
    assign job_pop   = en && job_valid;
    assign res_valid = vld_reg[PIPE_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], job_valid};
        end
    end

    // stage 1: products
    logic signed [PROD_W-1:0] pp1_reg [3][3];
    logic signed [PROD_W-1:0] np1_reg [3][3];
    word_t                    tr1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    pp1_reg[r][c] <= $signed(job.pos[c]) * $signed(job.coef[4 * r + c]);
                    np1_reg[r][c] <= $signed(job.nrm[c]) * $signed(job.coef[4 * r + c]);
                end
                tr1_reg[r] <= job.coef[4 * r + 3];
            end
        end
    end

    // stages 2 and 3: sums
    logic signed [SUM_W-1:0] ps2_reg [3];
    logic signed [SUM_W-1:0] pt2_reg [3];
    logic signed [SUM_W-1:0] ns2_reg [3];
    logic signed [SUM_W-1:0] nt2_reg [3];
    logic signed [SUM_W-1:0] psum3_reg [3];
    logic signed [SUM_W-1:0] nsum3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                ps2_reg[r]   <= SUM_W'(pp1_reg[r][0]) + SUM_W'(pp1_reg[r][1]);
                pt2_reg[r]   <= SUM_W'(pp1_reg[r][2])
                              + (SUM_W'(tr1_reg[r]) <<< POS_FRAC_BITS) + ROUND_HALF;
                ns2_reg[r]   <= SUM_W'(np1_reg[r][0]) + SUM_W'(np1_reg[r][1]);
                nt2_reg[r]   <= SUM_W'(np1_reg[r][2]);
                psum3_reg[r] <= ps2_reg[r] + pt2_reg[r];
                nsum3_reg[r] <= ns2_reg[r] + nt2_reg[r];
            end
        end
    end

    // stage 4: round, saturate, magnitude and sign
    logic signed [SUM_W-1:0] psh   [3];
    logic signed [SUM_W-1:0] nabs  [3];
    logic        [2:0]       inrng;
    side_t                   side4;
    logic        [MAG_W-1:0] mag4_reg [3];
    side_t                   side_reg [SIDE_LEN];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            psh[r]   = psum3_reg[r] >>> COEF_FRAC_BITS;
            inrng[r] = (&psh[r][SUM_W-1:WORD_W-1]) || !(|psh[r][SUM_W-1:WORD_W-1]);
            nabs[r]  = nsum3_reg[r][SUM_W-1] ? -nsum3_reg[r] : nsum3_reg[r];
            side4.neg[r] = nsum3_reg[r][SUM_W-1];
            if (inrng[r])
            begin
                side4.pos[r] = psh[r][WORD_W-1:0];
            end
            else
            begin
                side4.pos[r] = psh[r][SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                               : {1'b0, {(WORD_W-1){1'b1}}};
            end
        end
        side4.sat = !(&inrng);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                mag4_reg[r] <= nabs[r][MAG_W-1:0];
            end
            side_reg[0] <= side4;
            for (int i = 1; i < SIDE_LEN; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // stage 5: largest magnitude, then six normalizing shift steps
    logic [MAG_W-1:0] mx4;
    logic [MAG_W-1:0] nm_reg  [NORM_STEPS+1][3];
    logic [MAG_W-1:0] nmx_reg [NORM_STEPS+1];

    always_comb
    begin
        mx4 = mag4_reg[0];
        if (mag4_reg[1] > mx4)
        begin
            mx4 = mag4_reg[1];
        end
        if (mag4_reg[2] > mx4)
        begin
            mx4 = mag4_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                nm_reg[0][r] <= mag4_reg[r];
            end
            nmx_reg[0] <= mx4;
        end
    end

    for (genvar k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        localparam int SH = (MAG_W / 2) >> k;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (nmx_reg[k][MAG_W-1 -: SH] == '0)
                begin
                    nmx_reg[k+1] <= nmx_reg[k] << SH;
                    for (int r = 0; r < 3; r++)
                    begin
                        nm_reg[k+1][r] <= nm_reg[k][r] << SH;
                    end
                end
                else
                begin
                    nmx_reg[k+1] <= nmx_reg[k];
                    for (int r = 0; r < 3; r++)
                    begin
                        nm_reg[k+1][r] <= nm_reg[k][r];
                    end
                end
            end
        end
    end

    // stages 12 and 13: squares and their sum
    logic [NMAG_W-1:0] a12_reg  [3];
    logic [MAG_W-1:0]  sq12_reg [3];
    logic [MAG_W-1:0]  srem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] sroot_reg [ROOT_W+1];
    logic [NMAG_W-1:0] sa_reg    [ROOT_W+1][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                a12_reg[r]  <= nm_reg[NORM_STEPS][r][MAG_W-1 -: NMAG_W];
                sq12_reg[r] <= MAG_W'(nm_reg[NORM_STEPS][r][MAG_W-1 -: NMAG_W])
                             * MAG_W'(nm_reg[NORM_STEPS][r][MAG_W-1 -: NMAG_W]);
                sa_reg[0][r] <= a12_reg[r];
            end
            srem_reg[0]  <= sq12_reg[0] + sq12_reg[1] + sq12_reg[2];
            sroot_reg[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic [MAG_W-1:0] test;
        assign test = (MAG_W'(sroot_reg[k]) << (B + 1)) + (MAG_W'(1) << (2 * B));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (srem_reg[k] >= test)
                begin
                    srem_reg[k+1]  <= srem_reg[k] - test;
                    sroot_reg[k+1] <= sroot_reg[k] | (ROOT_W'(1) << B);
                end
                else
                begin
                    srem_reg[k+1]  <= srem_reg[k];
                    sroot_reg[k+1] <= sroot_reg[k];
                end
                for (int r = 0; r < 3; r++)
                begin
                    sa_reg[k+1][r] <= sa_reg[k][r];
                end
            end
        end
    end

    // rounded division of each component by the length
    logic [ROOT_W-1:0] dl_reg   [QUO_W+1];
    logic [REM_W-1:0]  drem_reg [QUO_W+1][3];
    logic [QUO_W-1:0]  dq_reg   [QUO_W+1][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= sroot_reg[ROOT_W];
            for (int r = 0; r < 3; r++)
            begin
                drem_reg[0][r] <= REM_W'({sa_reg[ROOT_W][r], 15'b0})
                                + REM_W'(sroot_reg[ROOT_W] >> 1);
                dq_reg[0][r]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int B = QUO_W - 1 - k;
        logic [REM_W-1:0] trial;
        assign trial = REM_W'(dl_reg[k]) << B;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dl_reg[k+1] <= dl_reg[k];
                for (int r = 0; r < 3; r++)
                begin
                    if (drem_reg[k][r] >= trial)
                    begin
                        drem_reg[k+1][r] <= drem_reg[k][r] - trial;
                        dq_reg[k+1][r]   <= dq_reg[k][r] | (QUO_W'(1) << B);
                    end
                    else
                    begin
                        drem_reg[k+1][r] <= drem_reg[k][r];
                        dq_reg[k+1][r]   <= dq_reg[k][r];
                    end
                end
            end
        end
    end

    // output stage: clamp, restore sign
    vat_result_t      res_next;
    vat_result_t      res_reg;
    logic [QUO_W-1:0] qc;
    logic [QUO_W-1:0] qn;
    side_t            side_out;

    always_comb
    begin
        side_out  = side_reg[SIDE_LEN-1];
        res_next.pos = side_out.pos;
        res_next.pos_saturated = side_out.sat;
        res_next.zero_normal   = (dl_reg[QUO_W] == '0);
        qc = '0;
        qn = '0;
        for (int r = 0; r < 3; r++)
        begin
            qc = (dq_reg[QUO_W][r] > QUO_W'(32768)) ? QUO_W'(32768) : dq_reg[QUO_W][r];
            qn = QUO_W'(65536) - qc;
            if (res_next.zero_normal)
            begin
                res_next.nrm[r] = '0;
            end
            else if (side_out.neg[r])
            begin
                res_next.nrm[r] = qn[NRM_W-1:0];
            end
            else
            begin
                res_next.nrm[r] = (qc > QUO_W'(32767)) ? NRM_W'(32767) : qc[NRM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

/* rtl/vertex_affine_transform_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_affine_transform_unit
// 3x4 affine vertex transform with unit-length normal output
// ----------------------------------------------------------------------------
//  channel   | dir | handshake         | contents
//  s_*       | in  | s_tvalid/s_tready | load (tuser 0) or vertex (tuser 1)
//  m_*       | out | m_tvalid/m_tready | transformed vertex, one per vertex
//
//  one item per cycle unless m_tready stalls and the queue fills; m_tvalid for a vertex
//  rises after the queue and the product, sum, normalize, 32-stage root and 17-stage divide pipeline
//  loads take effect for the next vertex and give no transaction
//  reset sets the matrix to identity and empties the pipeline
//  a stalled m_tready freezes the back pipeline while m_tvalid is high; a two-entry queue
//  keeps s_tready up until it fills
// ----------------------------------------------------------------------------
module vertex_affine_transform_unit
    import vat_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // coef_index, coef_value, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_x, out_y, out_z, out_nx, out_ny, out_nz
    output logic [M_TDATA_W-1:0]      m_tdata,
    // zero_normal, pos_saturated
    output logic [M_TUSER_W-1:0]      m_tuser
);

    logic        q_full;
    logic        q_push;
    vat_job_t    q_in;
    logic        q_pop;
    logic        q_valid;
    vat_job_t    q_out;
    vat_result_t res;

    vat_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_in)
    );

    vat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .job_valid (q_valid),
        .job       (q_out)
    );

    vat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_out),
        .job_pop   (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {res.nrm[2], res.nrm[1], res.nrm[0],
                      res.pos[2], res.pos[1], res.pos[0]};
    assign m_tuser = {res.pos_saturated, res.zero_normal};

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the vertex affine transform unit against a behavioral predictor:
// directed matrix loads, rounding, saturation and normal corner cases, then
// random load/vertex streams under three sender and receiver stall patterns
// ----------------------------------------------------------------------------
module tb_top;
    import vat_pkg::*;

    typedef struct {
        word_t  pos [3];
        nrm16_t nrm [3];
        logic   zero_normal;
        logic   pos_saturated;
    } vertex_out_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    word_t       mtx [NCOEF];
    vertex_out_t pending_vertices [$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_loads;
    int          n_zero_nrm;
    int          n_sat;
    int          tx_idle_pct;
    int          rx_idle_pct;

    vertex_affine_transform_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // exact affine transform of one vertex with the current matrix
    function automatic vertex_out_t transform_vertex(word_t p [3], word_t n [3]);
        vertex_out_t        res;
        logic signed [127:0] acc;
        longint unsigned    mag [3];
        longint unsigned    mx;
        longint unsigned    len;
        longint unsigned    q;
        logic               neg [3];
        res.pos_saturated = 1'b0;
        mx = 0;
        for (int r = 0; r < 3; r++)
        begin
            acc = 0;
            for (int c = 0; c < 3; c++)
                acc += longint'(p[c]) * longint'(mtx[4*r+c]);
            acc += longint'(mtx[4*r+3]) <<< 16;
            acc += longint'(1) <<< (COEF_FRAC_BITS - 1);
            acc = acc >>> COEF_FRAC_BITS;
            if (acc > 128'sd2147483647)
            begin
                res.pos[r] = 32'h7FFF_FFFF;
                res.pos_saturated = 1'b1;
            end
            else if (acc < -128'sd2147483648)
            begin
                res.pos[r] = 32'h8000_0000;
                res.pos_saturated = 1'b1;
            end
            else
                res.pos[r] = acc[31:0];
        end
        for (int r = 0; r < 3; r++)
        begin
            acc = 0;
            for (int c = 0; c < 3; c++)
                acc += longint'(n[c]) * longint'(mtx[4*r+c]);
            neg[r] = acc < 0;
            if (neg[r])
                acc = -acc;
            mag[r] = acc[63:0];
            if (mag[r] > mx)
                mx = mag[r];
        end
        if (mx == 0)
        begin
            for (int r = 0; r < 3; r++)
                res.nrm[r] = '0;
            res.zero_normal = 1'b1;
        end
        else
        begin
            while (mx >= (64'd1 << 31))
            begin
                mx >>= 1;
                for (int r = 0; r < 3; r++)
                    mag[r] >>= 1;
            end
            while (mx < (64'd1 << 30))
            begin
                mx <<= 1;
                for (int r = 0; r < 3; r++)
                    mag[r] <<= 1;
            end
            len = isqrt64(mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2]);
            for (int r = 0; r < 3; r++)
            begin
                q = ((mag[r] << 15) + len / 2) / len;
                if (q > 32768)
                    q = 32768;
                if (neg[r])
                    res.nrm[r] = 16'(17'h10000 - 17'(q));
                else
                    res.nrm[r] = (q > 32767) ? 16'sd32767 : 16'(q);
            end
            res.zero_normal = 1'b0;
        end
        return res;
    endfunction

    task automatic report(string what, int got, int exp_val);
        errors++;
        if (errors <= 30)
            $display("mismatch %0s: got %h expected %h at %0t", what, got, exp_val, $realtime);
    endtask

    // one transaction on the slave side, with a random hold-off before it
    task automatic send_item(op_t op, logic [3:0] idx, word_t coef, word_t p [3], word_t n [3]);
        vertex_out_t res;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, n[2], n[1], n[0], p[2], p[1], p[0], coef, idx};
        do
            @(posedge clk);
        while (!s_tready);
        n_sent++;
        if (op == OP_LOAD)
        begin
            n_loads++;
            if (idx < NCOEF)
                mtx[idx] = coef;
        end
        else
        begin
            res = transform_vertex(p, n);
            n_zero_nrm += res.zero_normal;
            n_sat += res.pos_saturated;
            pending_vertices.insert(pending_vertices.size(), res);
        end
    endtask

    task automatic load_coef(int idx, word_t v);
        word_t z [3] = '{$urandom, $urandom, $urandom};
        send_item(OP_LOAD, 4'(idx), v, z, z);
    endtask

    task automatic send_vertex(word_t px, word_t py, word_t pz, word_t nx, word_t ny, word_t nz);
        word_t p [3] = '{px, py, pz};
        word_t n [3] = '{nx, ny, nz};
        send_item(OP_XFORM, 4'($urandom), $urandom, p, n);
    endtask

    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_vertices.size() == 0);
    endtask

    always @(posedge clk)
    begin
        vertex_out_t e;
        if (m_tvalid && m_tready)
        begin
            if (pending_vertices.size() == 0)
                report("unexpected transaction", 0, 0);
            else
            begin
                e = pending_vertices.pop_front();
                n_checked++;
                for (int r = 0; r < 3; r++)
                begin
                    if (word_t'(m_tdata[32*r +: 32]) !== e.pos[r])
                        report($sformatf("pos[%0d]", r), m_tdata[32*r +: 32], e.pos[r]);
                    if (nrm16_t'(m_tdata[96+16*r +: 16]) !== e.nrm[r])
                        report($sformatf("nrm[%0d]", r), m_tdata[96+16*r +: 16], e.nrm[r]);
                end
                if (m_tuser[0] !== e.zero_normal)
                    report("zero_normal", m_tuser[0], e.zero_normal);
                if (m_tuser[1] !== e.pos_saturated)
                    report("pos_saturated", m_tuser[1], e.pos_saturated);
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    function automatic word_t rand_coef();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return word_t'($urandom_range(0, 1 << 19)) - (1 << 18);
        else if (k < 70)
            return $urandom;
        else if (k < 85)
            return '0;
        return $urandom_range(0, 1) ? word_t'(COEF_ONE) : -word_t'(COEF_ONE);
    endfunction

    function automatic word_t rand_val();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return word_t'($urandom_range(0, 1 << 27)) - (1 << 26);
        else if (k < 90)
            return $urandom;
        else if (k < 95)
            return '0;
        return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    task automatic test_identity;
        send_vertex(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 0, 0, 32'sh0001_0000);
        send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 0, -32'sh0001_0000, 0, 0);
        send_vertex(1, -1, 0, 0, 0, 0);
        send_vertex(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    task automatic test_rounding_saturation;
        load_coef(0, 32'sh0000_8000);       // half: position ties
        send_vertex(1, 0, 0, 1, 1, 1);
        send_vertex(-1, 0, 0, 0, -1, 0);
        load_coef(0, 32'sh7FFF_FFFF);
        send_vertex(32'sh7FFF_FFFF, 5, 7, 3, 0, 0);
        send_vertex(32'sh8000_0000, 0, 0, 32'sh8000_0000, 0, 0);
        load_coef(3, 32'sh7FFF_FFFF);       // translation extremes
        load_coef(7, 32'sh8000_0000);
        load_coef(11, 32'sh8000_0000);
        send_vertex(0, 0, 0, 0, 0, 0);
        load_coef(12, 32'sh1234_5678);      // indexes past the matrix are ignored
        load_coef(15, 32'sh7FFF_FFFF);
        send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1, 2, 3);
    endtask

    task automatic test_zero_matrix;
        for (int i = 0; i < NCOEF; i++)
            load_coef(i, '0);
        send_vertex(32'sh0100_0000, 0, 0, 32'sh0001_0000, 0, 0);
        drain;
        for (int i = 0; i < NCOEF; i++)
            load_coef(i, (i % 5 == 0) ? word_t'(COEF_ONE) : '0);
    endtask

    task automatic test_random(int items);
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                for (int k = 0; k < NCOEF; k++)
                    load_coef(k, rand_coef());
            else if ($urandom_range(0, 99) < 20)
                load_coef($urandom_range(0, 15), rand_coef());
            else
                send_vertex(rand_val(), rand_val(), rand_val(),
                            rand_val(), rand_val(), rand_val());
            if (i == items / 2)
                drain;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_loads = 0;
        n_zero_nrm = 0;
        n_sat = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < NCOEF; i++)
            mtx[i] = (i % 5 == 0) ? word_t'(COEF_ONE) : '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_identity;
        test_rounding_saturation;
        test_zero_matrix;
        tx_idle_pct = 25;
        rx_idle_pct = 55;
        test_random(280);
        tx_idle_pct = 55;
        rx_idle_pct = 25;
        test_random(280);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(280);
        drain;
        repeat (100) @(posedge clk);

        $display("sent %0d items (%0d loads), checked %0d vertices", n_sent, n_loads, n_checked);
        $display("zero normals %0d, saturated positions %0d", n_zero_nrm, n_sat);
        if (errors == 0 && pending_vertices.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/vat_pkg.sv
rtl/vat_front.sv
rtl/vat_queue.sv
rtl/vat_back.sv
rtl/vertex_affine_transform_unit.sv
tb/tb_top.sv
